// ----- rtl/tmu_pkg.sv -----
// Package for the transform matrix unit: payload structs, opcodes, back-end states.
// No dependencies.
package tmu_pkg;

    typedef enum logic [2:0] {
        OP_IDENT  = 3'd0,
        OP_WR_CUR = 3'd1,
        OP_WR_OPD = 3'd2,
        OP_READ   = 3'd3,
        OP_TRANS  = 3'd4,
        OP_SCALE  = 3'd5,
        OP_MUL    = 3'd6,
        OP_NOP    = 3'd7
    } t_opcode;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] x_val;
        logic signed [31:0] y_val;
        logic signed [31:0] z_val;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic               saturated;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2
    } t_be_state;

    // Sum of four truncated products plus one term: 32+32-16 bits each at 16 fraction bits, plus carry room.
    localparam int ACC_W = 66;
    localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32 = 32'sh80000000;

endpackage

// ----- rtl/tmu_queue.sv -----
// Two-entry item queue between the front end and the back end.
// Depends on tmu_pkg.
module tmu_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tmu_pkg::t_in_item i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output tmu_pkg::t_in_item o_data
);
    tmu_pkg::t_in_item r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    property p_no_over;
        @(posedge i_clk) disable iff (!i_rst_n) o_full |=> r_cnt != 2'd3;
    endproperty
    a_no_over: assert property (p_no_over) else $error("queue count overflow");
    a_cnt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) == (r_wp == r_rp) || r_cnt == 2'd2)
        else $error("queue pointers disagree with count");
    a_pop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !i_push) |=> o_empty) else $error("queue filled with no push");
endmodule

// ----- rtl/tmu_back.sv -----
// Back end: matrix storage, shared four-term dot unit, result register.
// Depends on tmu_pkg.
module tmu_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  tmu_pkg::t_in_item  i_item,
    output logic               o_pop,
    output logic               o_empty,
    output tmu_pkg::t_out_item o_res,
    input  logic               i_pop
);
    localparam int AW = tmu_pkg::ACC_W;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0] r_cur [16];
    logic signed [31:0] r_opd [16];
    logic signed [31:0] r_new [16];
    tmu_pkg::t_be_state r_st, n_st;
    logic [4:0]         r_cnt;
    logic               r_sat;
    logic               r_rv;
    tmu_pkg::t_out_item r_res;

    logic [3:0] w_i;
    logic [1:0] w_r, w_c;
    logic signed [31:0] a0, a1, a2, a3, b0, b1, b2, b3, w_add;
    logic signed [63:0] p0, p1, p2, p3;
    logic signed [AW-1:0] s;
    logic signed [31:0] w_cl;
    logic w_ov;
    logic [3:0] w_len;
    logic w_last, w_start, w_fin;
    tmu_pkg::t_opcode w_op;

    assign w_op = tmu_pkg::t_opcode'(i_item.opcode);
    assign w_i  = r_cnt[3:0];
    assign w_r  = w_i[1:0];
    assign w_c  = w_i[3:2];

    // One result element per step: translate sweeps 4 rows, scale 12, multiply 16.
    always_comb begin
        case (w_op)
            tmu_pkg::OP_TRANS: w_len = 4'd3;
            tmu_pkg::OP_SCALE: w_len = 4'd11;
            default:           w_len = 4'd15;
        endcase
    end

    // Operand selection for the dot unit.
    always_comb begin
        a0 = '0; a1 = '0; a2 = '0; a3 = '0;
        b0 = '0; b1 = '0; b2 = '0; b3 = '0;
        w_add = '0;
        case (w_op)
            tmu_pkg::OP_TRANS: begin
                a0 = r_cur[{2'd0, w_r}]; b0 = i_item.x_val;
                a1 = r_cur[{2'd1, w_r}]; b1 = i_item.y_val;
                a2 = r_cur[{2'd2, w_r}]; b2 = i_item.z_val;
                w_add = r_cur[{2'd3, w_r}];
            end
            tmu_pkg::OP_SCALE: begin
                a0 = r_cur[w_i];
                b0 = (w_c == 2'd0) ? i_item.x_val :
                     (w_c == 2'd1) ? i_item.y_val : i_item.z_val;
            end
            default: begin
                a0 = r_cur[{2'd0, w_r}]; b0 = r_opd[{w_c, 2'd0}];
                a1 = r_cur[{2'd1, w_r}]; b1 = r_opd[{w_c, 2'd1}];
                a2 = r_cur[{2'd2, w_r}]; b2 = r_opd[{w_c, 2'd2}];
                a3 = r_cur[{2'd3, w_r}]; b3 = r_opd[{w_c, 2'd3}];
            end
        endcase
    end

    assign p0 = a0 * b0;
    assign p1 = a1 * b1;
    assign p2 = a2 * b2;
    assign p3 = a3 * b3;
    assign s = AW'(p0 >>> FRAC_BITS) + AW'(p1 >>> FRAC_BITS)
             + AW'(p2 >>> FRAC_BITS) + AW'(p3 >>> FRAC_BITS) + AW'(w_add);

    always_comb begin
        w_ov = 1'b1;
        if (s > AW'(tmu_pkg::MAX32))      w_cl = tmu_pkg::MAX32;
        else if (s < AW'(tmu_pkg::MIN32)) w_cl = tmu_pkg::MIN32;
        else begin
            w_cl = s[31:0];
            w_ov = 1'b0;
        end
    end

    assign w_start = !i_empty && !r_rv && r_st == tmu_pkg::ST_IDLE;
    assign w_last  = (w_i == w_len);

    always_comb begin
        n_st = r_st;
        case (r_st)
            tmu_pkg::ST_IDLE:
                if (w_start) begin
                    if (w_op == tmu_pkg::OP_TRANS || w_op == tmu_pkg::OP_SCALE ||
                        w_op == tmu_pkg::OP_MUL)
                        n_st = tmu_pkg::ST_RUN;
                end
            tmu_pkg::ST_RUN:  if (w_last) n_st = tmu_pkg::ST_DONE;
            tmu_pkg::ST_DONE: n_st = tmu_pkg::ST_IDLE;
            default:          n_st = tmu_pkg::ST_IDLE;
        endcase
    end

    // Finish: a short op at start, a swept op in its commit state.
    assign w_fin = (r_st == tmu_pkg::ST_DONE) ||
                   (w_start && n_st == tmu_pkg::ST_IDLE);
    assign o_pop = w_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tmu_pkg::ST_IDLE;
            r_cnt <= '0;
            r_rv <= 1'b0;
            for (int k = 0; k < 16; k++) begin
                r_cur[k] <= (k % 5 == 0) ? ONE : 32'sd0;
                r_opd[k] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (r_rv && i_pop) r_rv <= 1'b0;
            if (w_fin) r_rv <= 1'b1;
            if (r_st == tmu_pkg::ST_RUN) r_cnt <= r_cnt + 5'd1;
            else r_cnt <= '0;
            if (w_start) begin
                case (w_op)
                    tmu_pkg::OP_IDENT:
                        for (int k = 0; k < 16; k++) r_cur[k] <= (k % 5 == 0) ? ONE : 32'sd0;
                    tmu_pkg::OP_WR_CUR: r_cur[i_item.elem_index] <= i_item.elem_value;
                    tmu_pkg::OP_WR_OPD: r_opd[i_item.elem_index] <= i_item.elem_value;
                    default: ;
                endcase
            end
            if (r_st == tmu_pkg::ST_DONE) begin
                case (w_op)
                    tmu_pkg::OP_TRANS:
                        for (int k = 0; k < 4; k++) r_cur[12+k] <= r_new[k];
                    tmu_pkg::OP_SCALE:
                        for (int k = 0; k < 12; k++) r_cur[k] <= r_new[k];
                    default:
                        for (int k = 0; k < 16; k++) r_cur[k] <= r_new[k];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == tmu_pkg::ST_RUN) begin
            r_new[w_i] <= w_cl;
            r_sat <= r_sat | w_ov;
        end else begin
            r_sat <= 1'b0;
        end
        if (w_fin) begin
            r_res.read_data <= (w_start && w_op == tmu_pkg::OP_READ) ?
                               r_cur[i_item.elem_index] : 32'sd0;
            r_res.saturated <= (r_st == tmu_pkg::ST_DONE) ? r_sat : 1'b0;
        end
    end

    assign o_empty = !r_rv;
    assign o_res   = r_res;

    a_fin_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |-> !r_rv) else $error("result overwritten");
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == tmu_pkg::ST_RUN |-> r_cnt < 5'd16) else $error("sweep overran");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == tmu_pkg::ST_DONE |=> r_st == tmu_pkg::ST_IDLE)
        else $error("commit state repeated");
endmodule

// ----- rtl/transform_matrix_unit_top.sv -----
// Transform matrix unit top: front queue and back end; depends on tmu_pkg, tmu_queue, tmu_back.
// Identity, writes, read and the unused code finish when taken from the queue; translate,
// scale and multiply sweep one element per cycle through the shared dot unit, then commit.
// A waiting result holds the back end, and the two-entry queue takes new items meanwhile.
// Reset (synchronous, active low): current matrix to identity, operand to zero, all empty.
module transform_matrix_unit_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tmu_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output tmu_pkg::t_out_item o_item
);
    logic              w_qempty, w_qpop;
    tmu_pkg::t_in_item w_qdata;

    // Front: buffer incoming items so the caller need not wait on a long sweep while the queue has room.
    tmu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_item),
        .o_full  (full),
        .i_pop   (w_qpop),
        .o_empty (w_qempty),
        .o_data  (w_qdata)
    );

    // Back: execute one item at a time and hold its result until popped.
    tmu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_qempty),
        .i_item  (w_qdata),
        .o_pop   (w_qpop),
        .o_empty (empty),
        .o_res   (o_item),
        .i_pop   (pop)
    );
endmodule

// ----- bench/transform_matrix_unit_top_test.sv -----
// Self-checking bench for transform_matrix_unit_top: directed and random opcodes,
// predicted by a fixed-point 4x4 matrix model kept here. Depends on tmu_pkg and the RTL.
`timescale 1ns / 100ps

module transform_matrix_unit_top_test;

    localparam int FRAC = 16;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    tmu_pkg::t_in_item  in_item;
    logic               empty;
    logic               pop;
    tmu_pkg::t_out_item out_item;

    transform_matrix_unit_top #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .push    (push),
        .full    (full),
        .i_item  (in_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (out_item)
    );

    // Predictor state: both matrices, column-major.
    logic signed [31:0] cur_mat [16];
    logic signed [31:0] opd_mat [16];
    tmu_pkg::t_out_item expected_q [$];

    int  n_errors;
    int  n_items;
    int  n_results;
    int  n_saturated;
    bit  hold_off;       // receiver long stall request
    bit  pop_gaps = 1'b1;

    always #5 clk = ~clk;

    // Truncating fixed-point product: exact 64-bit product shifted arithmetically.
    function automatic logic signed [63:0] fx_product(logic signed [31:0] a,
                                                      logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p >>> FRAC;
    endfunction

    function automatic logic signed [31:0] clamp_sum(logic signed [65:0] v, ref bit sat);
        if (v > 66'sh0_7fff_ffff) begin
            sat = 1'b1;
            return tmu_pkg::MAX32;
        end
        if (v < -66'sh0_8000_0000) begin
            sat = 1'b1;
            return tmu_pkg::MIN32;
        end
        return v[31:0];
    endfunction

    function automatic void set_identity();
        for (int i = 0; i < 16; i++) cur_mat[i] = (i % 5 == 0) ? ONE : '0;
    endfunction

    // Apply one item to the matrices and return the result it should produce.
    function automatic tmu_pkg::t_out_item apply_matrix_op(tmu_pkg::t_in_item it);
        tmu_pkg::t_out_item res;
        bit                 sat;
        logic signed [65:0] acc;
        logic signed [31:0] prod [16];
        sat = 1'b0;
        res = '0;
        case (tmu_pkg::t_opcode'(it.opcode))
            tmu_pkg::OP_IDENT:  set_identity();
            tmu_pkg::OP_WR_CUR: cur_mat[it.elem_index] = it.elem_value;
            tmu_pkg::OP_WR_OPD: opd_mat[it.elem_index] = it.elem_value;
            tmu_pkg::OP_READ:   res.read_data = cur_mat[it.elem_index];
            tmu_pkg::OP_TRANS: begin
                for (int r = 0; r < 4; r++) begin
                    acc = 66'(fx_product(cur_mat[r], it.x_val))
                        + 66'(fx_product(cur_mat[4 + r], it.y_val))
                        + 66'(fx_product(cur_mat[8 + r], it.z_val))
                        + 66'(cur_mat[12 + r]);
                    cur_mat[12 + r] = clamp_sum(acc, sat);
                end
            end
            tmu_pkg::OP_SCALE: begin
                for (int r = 0; r < 4; r++) begin
                    cur_mat[r]     = clamp_sum(66'(fx_product(cur_mat[r], it.x_val)), sat);
                    cur_mat[4 + r] = clamp_sum(66'(fx_product(cur_mat[4 + r], it.y_val)), sat);
                    cur_mat[8 + r] = clamp_sum(66'(fx_product(cur_mat[8 + r], it.z_val)), sat);
                end
            end
            tmu_pkg::OP_MUL: begin
                // every new element uses the old current matrix
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) begin
                        acc = '0;
                        for (int k = 0; k < 4; k++)
                            acc += 66'(fx_product(cur_mat[k * 4 + r], opd_mat[c * 4 + k]));
                        prod[c * 4 + r] = clamp_sum(acc, sat);
                    end
                for (int i = 0; i < 16; i++) cur_mat[i] = prod[i];
            end
            default: ;
        endcase
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
        n_errors++;
    endtask

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one item: offer it, hold until accepted, then idle at random when gaps is set.
    task automatic send_item(tmu_pkg::t_in_item it, bit gaps = 1'b1);
        int idle;
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        // accepted at this edge: predict now, in acceptance order
        expected_q.push_back(apply_matrix_op(it));
        n_items++;
        idle = gaps ? gap_len() : 0;
        if (idle > 0) begin
            push <= 1'b0;
            repeat (idle) @(posedge clk);
        end
    endtask

    // Drop the request and wait on the clock before anything else drives it.
    task automatic drop_push();
        push <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return tmu_pkg::MAX32;
            1: return tmu_pkg::MIN32;
            2: return $urandom_range(0, 1) ? ONE : -ONE;
            3: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
            4: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic tmu_pkg::t_in_item make_item(tmu_pkg::t_opcode op);
        tmu_pkg::t_in_item it;
        it.opcode     = op;
        it.elem_index = 4'($urandom_range(0, 15));
        it.elem_value = rand_value();
        it.x_val      = rand_value();
        it.y_val      = rand_value();
        it.z_val      = rand_value();
        return it;
    endfunction

    // Result side: pop with random stalls, check against oldest expectation.
    always @(posedge clk) begin
        tmu_pkg::t_out_item want;
        if (rst_n && pop && !empty) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", out_item.read_data, '0);
            end else begin
                want = expected_q.pop_front();
                if (out_item.read_data !== want.read_data)
                    report_mismatch("read_data", out_item.read_data, want.read_data);
                if (out_item.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(out_item.saturated), 32'(want.saturated));
                n_results++;
                if (want.saturated) n_saturated++;
            end
        end
    end

    // Pop driver: random stalls, or a long hold-off on request.
    initial begin
        int idle;
        pop <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off) begin
                pop <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            idle = pop_gaps ? gap_len() : 0;
            if (idle > 0) begin
                pop <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    // Directed: extremes, every opcode, readback of all elements.
    task automatic test_directed();
        tmu_pkg::t_in_item it;
        it = make_item(tmu_pkg::OP_READ);
        it.elem_index = 4'd0;
        send_item(it);                     // reset identity visible
        it = make_item(tmu_pkg::OP_WR_CUR);
        it.elem_index = 4'd15;
        it.elem_value = tmu_pkg::MAX32;
        send_item(it);
        it.opcode = tmu_pkg::OP_READ;
        send_item(it);
        it = make_item(tmu_pkg::OP_WR_CUR);
        it.elem_index = 4'd5;
        it.elem_value = tmu_pkg::MIN32;
        send_item(it);
        it = make_item(tmu_pkg::OP_SCALE); // scale overflow
        it.x_val = tmu_pkg::MAX32; it.y_val = tmu_pkg::MIN32; it.z_val = -ONE;
        send_item(it);
        it.opcode = tmu_pkg::OP_READ; it.elem_index = 4'd5;
        send_item(it);
        send_item(make_item(tmu_pkg::OP_IDENT));
        it = make_item(tmu_pkg::OP_TRANS); // sum saturation on the fourth column
        it.x_val = tmu_pkg::MAX32; it.y_val = tmu_pkg::MAX32; it.z_val = tmu_pkg::MAX32;
        send_item(it);
        it.x_val = tmu_pkg::MIN32; it.y_val = 32'sh0000_8000; it.z_val = '0;
        send_item(it);
        for (int i = 0; i < 16; i++) begin
            it = make_item(tmu_pkg::OP_WR_OPD);
            it.elem_index = i[3:0];
            it.elem_value = (i % 5 == 0) ? 32'sh0002_0000 : 32'sh7fff_0000;
            send_item(it);
        end
        send_item(make_item(tmu_pkg::OP_MUL));
        send_item(make_item(tmu_pkg::OP_NOP));  // unused opcode
        for (int i = 0; i < 16; i++) begin
            it = make_item(tmu_pkg::OP_READ);
            it.elem_index = i[3:0];
            send_item(it);
        end
        drop_push();
    endtask

    // Random: mostly well-formed sequences (writes, transforms, reads back).
    task automatic test_random(int count);
        tmu_pkg::t_in_item it;
        int                roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 25)      it = make_item(tmu_pkg::OP_READ);
            else if (roll < 40) it = make_item(tmu_pkg::OP_WR_CUR);
            else if (roll < 55) it = make_item(tmu_pkg::OP_WR_OPD);
            else if (roll < 65) it = make_item(tmu_pkg::OP_TRANS);
            else if (roll < 75) it = make_item(tmu_pkg::OP_SCALE);
            else if (roll < 88) it = make_item(tmu_pkg::OP_MUL);
            else if (roll < 96) it = make_item(tmu_pkg::OP_IDENT);
            else begin
                it = make_item(tmu_pkg::OP_NOP);
                it.opcode = 3'($urandom_range(0, 7));  // any opcode, random junk fields
            end
            send_item(it);
        end
        drop_push();
    endtask

    // Back-pressure: stall the receiver while items keep coming.
    task automatic test_backpressure();
        hold_off = 1'b1;
        pop_gaps = 1'b0;
        repeat (60)
            send_item(make_item($urandom_range(0, 1) ? tmu_pkg::OP_READ : tmu_pkg::OP_MUL),
                      1'b0);
        drop_push();
        pop_gaps = 1'b1;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        push     = 1'b0;
        in_item  = '0;
        hold_off = 1'b0;
        n_errors = 0;
        for (int i = 0; i < 16; i++) opd_mat[i] = '0;
        set_identity();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(1000);
        wait_drained();
        $display("Ran %0d items, checked %0d results (%0d saturated).",
                 n_items, n_results, n_saturated);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
